// ===== hdl/gdh_pkg.sv =====
package gdh_pkg;

   // Sizing of the count store.
   localparam int MAX_GRID   = 32;
   localparam int COUNT_BITS = 16;
   localparam int CELLS      = MAX_GRID * MAX_GRID;
   localparam int ADDR_BITS  = (CELLS > 1) ? $clog2(CELLS) : 1;

   // Field widths.
   localparam int OP_BITS        = 2;
   localparam int COORD_BITS     = 10;
   localparam int SPAN_BITS      = 10;
   localparam int IDX_BITS       = 10;
   localparam int G_BITS         = 6;
   localparam int K_BITS         = G_BITS + 1;
   localparam int OUT_COUNT_BITS = 16;
   localparam int EDGE_BITS      = 15;
   localparam int Q_SHIFT        = 4;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_LEFT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_TOP    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_SIZE   = 3'd4;

   localparam logic [SPAN_BITS-1:0]  RST_AREA_LEFT   = 10'd0;
   localparam logic [SPAN_BITS-1:0]  RST_AREA_TOP    = 10'd0;
   localparam logic [SPAN_BITS-1:0]  RST_AREA_WIDTH  = 10'd640;
   localparam logic [SPAN_BITS-1:0]  RST_AREA_HEIGHT = 10'd480;
   localparam logic [G_BITS-1:0]     RST_GRID_SIZE   = 6'd10;

   // Opcodes.
   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

   // Divider operand width: the widest dividend is an edge numerator,
   // 16 * k * span + g/2 with k up to MAX_GRID and span below 1024.
   localparam int DIV_BITS     = $clog2(16 * MAX_GRID * 1024);
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int SAT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   typedef struct packed {
      logic                 start;
      logic [DIV_BITS-1:0]  dividend;
      logic [SPAN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_BITS-1:0]  quotient;
      logic [SPAN_BITS-1:0] remainder;
   } div_rsp_type;

   // Clamp a stored count to the reported count width.
   function automatic logic [OUT_COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
      logic [SAT_BITS-1:0] ext;
      ext = SAT_BITS'(c);
      if (ext > SAT_BITS'({OUT_COUNT_BITS{1'b1}})) begin
         return '1;
      end
      return OUT_COUNT_BITS'(ext);
   endfunction

endpackage

// ===== hdl/gdh_req_if.sv =====
interface gdh_req_if import gdh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    opcode;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic [IDX_BITS-1:0]   cell_index;

   modport source (output valid, output opcode, output point_x, output point_y,
                   output cell_index, input ready);
   modport sink   (input valid, input opcode, input point_x, input point_y,
                   input cell_index, output ready);
endinterface

// ===== hdl/gdh_rsp_if.sv =====
interface gdh_rsp_if import gdh_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        out_of_range;
   logic [OUT_COUNT_BITS-1:0]   cell_count;
   logic                        cell_empty;
   logic signed [EDGE_BITS-1:0] bar_x_left;
   logic signed [EDGE_BITS-1:0] bar_x_right;
   logic signed [EDGE_BITS-1:0] bar_z_near;
   logic signed [EDGE_BITS-1:0] bar_z_far;

   modport source (output valid, output out_of_range, output cell_count, output cell_empty,
                   output bar_x_left, output bar_x_right, output bar_z_near,
                   output bar_z_far, input ready);
   modport sink   (input valid, input out_of_range, input cell_count, input cell_empty,
                   input bar_x_left, input bar_x_right, input bar_z_near,
                   input bar_z_far, output ready);
endinterface

// ===== hdl/gdh_count_ram.sv =====
module gdh_count_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/gdh_divider.sv =====
module gdh_divider import gdh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int DONE_LAT = DIV_BITS + 1;

   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [SPAN_BITS-1:0]    rem_ff, rem_in;
   logic [SPAN_BITS-1:0]    divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [SPAN_BITS:0]      trial;
   logic                    fits;

   // One restoring step per cycle: shift the next dividend bit into the
   // partial remainder and subtract the divisor when it fits.
   always_comb begin
      trial      = {rem_ff, quo_ff[DIV_BITS-1]};
      fits       = (trial >= {1'b0, divisor_ff});
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req.start) begin
         quo_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
         cnt_in     = DIV_CNT_BITS'(DIV_BITS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? SPAN_BITS'(trial - {1'b0, divisor_ff}) : trial[SPAN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      req.start |-> ##DONE_LAT done_ff)
      else $error("divider result not ready after the fixed latency");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (done_ff && divisor_ff != '0) |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== hdl/grid_density_histogram_top.sv =====
// Grid density histogram. Points are binned into a square grid of grid_size
// cells per side (clamped to MAX_GRID) laid over the rectangle set by the
// area registers, and each cell keeps a saturating count. An add item bins
// one point and bumps its cell; a point outside the grid is dropped and its
// result has out_of_range set. A read item returns the count of one cell,
// an empty flag and the cell's bar edges, centered on the area, in Q4 pixel
// units. A clear item zeros every count. Every item returns exactly one
// result item. The block works on one item at a time around a single
// restoring divider that produces one quotient bit per cycle. An add item
// divides once for its column and once for its row, and stops early when
// the point is rejected. A read item runs one division for row and column
// and one per bar edge. A clear item sweeps the count memory one entry a
// cycle. After reset the same sweep runs before the first item is
// accepted; configuration writes are taken during it. A finished result
// sits in an output register, so the next item is accepted while it
// waits. Configuration must only be written while the block is idle.
module grid_density_histogram_top import gdh_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   gdh_req_if.sink                  req_chan,
   gdh_rsp_if.source                rsp_chan
);

   typedef enum logic [14:0] {
      S_INIT      = 15'h0001,
      S_IDLE      = 15'h0002,
      S_BINX      = 15'h0004,
      S_BINX_WAIT = 15'h0008,
      S_BINY      = 15'h0010,
      S_BINY_WAIT = 15'h0020,
      S_ADDR      = 15'h0040,
      S_INC_RD    = 15'h0080,
      S_INC_WR    = 15'h0100,
      S_RD_CHK    = 15'h0200,
      S_RD_WAIT   = 15'h0400,
      S_EDGE      = 15'h0800,
      S_EDGE_WAIT = 15'h1000,
      S_CLEAR     = 15'h2000,
      S_DONE      = 15'h4000
   } state_type;

   localparam int BIN_PROD_BITS  = COORD_BITS + G_BITS;
   localparam int EDGE_PROD_BITS = K_BITS + SPAN_BITS;
   localparam int EC_BITS        = DIV_BITS + 2;
   localparam logic [ADDR_BITS-1:0] SWEEP_LAST = ADDR_BITS'(CELLS - 1);

   state_type state_ff, state_in;

   // Configuration registers.
   logic [SPAN_BITS-1:0] area_left_ff, area_left_in;
   logic [SPAN_BITS-1:0] area_top_ff, area_top_in;
   logic [SPAN_BITS-1:0] area_width_ff, area_width_in;
   logic [SPAN_BITS-1:0] area_height_ff, area_height_in;
   logic [G_BITS-1:0]    grid_size_ff, grid_size_in;

   // Captured item and working values.
   logic [OP_BITS-1:0]    op_ff, op_in;
   logic [COORD_BITS-1:0] px_ff, px_in;
   logic [COORD_BITS-1:0] py_ff, py_in;
   logic [IDX_BITS-1:0]   ci_ff, ci_in;
   logic [G_BITS-1:0]     col_ff, col_in;
   logic [G_BITS-1:0]     row_ff, row_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [ADDR_BITS-1:0]  sweep_ff, sweep_in;
   logic [1:0]            step_ff, step_in;

   // Result being built, and the output register.
   logic                        res_oor_ff, res_oor_in;
   logic [OUT_COUNT_BITS-1:0]   res_count_ff, res_count_in;
   logic                        res_empty_ff, res_empty_in;
   logic [EDGE_BITS-1:0]        bar_ff [4];
   logic [EDGE_BITS-1:0]        bar_in [4];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_oor_ff;
   logic [OUT_COUNT_BITS-1:0]   rsp_count_ff;
   logic                        rsp_empty_ff;
   logic [EDGE_BITS-1:0]        rsp_bar_ff [4];
   logic                        rsp_load;

   // Shared divider and count memory.
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic                  ram_re;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;

   // Derived operands.
   logic [G_BITS-1:0]         g_eff;
   logic [COORD_BITS-1:0]     dx, dy;
   logic [BIN_PROD_BITS-1:0]  binx_prod, biny_prod;
   logic [2*G_BITS-1:0]       g_sq;
   logic [K_BITS-1:0]         edge_k;
   logic [SPAN_BITS-1:0]      edge_span;
   logic [EDGE_PROD_BITS-1:0] edge_prod;
   logic [DIV_BITS-1:0]       edge_dividend;
   logic [EC_BITS-1:0]        edge_val;

   gdh_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gdh_count_ram #(
      .DEPTH (CELLS),
      .WIDTH (COUNT_BITS)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // The grid register is six bits wide, so the clamp is compared one bit wider.
   assign g_eff = ({1'b0, grid_size_ff} > (G_BITS + 1)'(MAX_GRID)) ?
                  G_BITS'(MAX_GRID) : grid_size_ff;

   assign dx        = px_ff - area_left_ff;
   assign dy        = py_ff - area_top_ff;
   assign binx_prod = BIN_PROD_BITS'(dx) * BIN_PROD_BITS'(g_eff);
   assign biny_prod = BIN_PROD_BITS'(dy) * BIN_PROD_BITS'(g_eff);
   assign g_sq      = (2 * G_BITS)'(g_eff) * (2 * G_BITS)'(g_eff);

   // Edge k of a cell sits at round(16 * k * span / g) from the area's
   // near side; the steps walk left, right, near and far edges in turn.
   assign edge_k        = (step_ff[1] ? K_BITS'(row_ff) : K_BITS'(col_ff)) +
                          K_BITS'(step_ff[0]);
   assign edge_span     = step_ff[1] ? area_height_ff : area_width_ff;
   assign edge_prod     = EDGE_PROD_BITS'(edge_k) * EDGE_PROD_BITS'(edge_span);
   assign edge_dividend = DIV_BITS'({edge_prod, {Q_SHIFT{1'b0}}}) +
                          DIV_BITS'(g_eff >> 1);
   assign edge_val      = EC_BITS'(div_rsp.quotient) -
                          EC_BITS'({edge_span, {(Q_SHIFT - 1){1'b0}}});

   always_comb begin
      area_left_in   = area_left_ff;
      area_top_in    = area_top_ff;
      area_width_in  = area_width_ff;
      area_height_in = area_height_ff;
      grid_size_in   = grid_size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_AREA_LEFT:   area_left_in   = csr_wdata[SPAN_BITS-1:0];
            CSR_AREA_TOP:    area_top_in    = csr_wdata[SPAN_BITS-1:0];
            CSR_AREA_WIDTH:  area_width_in  = csr_wdata[SPAN_BITS-1:0];
            CSR_AREA_HEIGHT: area_height_in = csr_wdata[SPAN_BITS-1:0];
            CSR_GRID_SIZE:   grid_size_in   = csr_wdata[G_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ci_in        = ci_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      sweep_in     = sweep_ff;
      step_in      = step_ff;
      res_oor_in   = res_oor_ff;
      res_count_in = res_count_ff;
      res_empty_in = res_empty_ff;
      bar_in       = bar_ff;
      div_req      = '0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;
      rsp_load     = 1'b0;

      case (state_ff)
         S_INIT, S_CLEAR: begin
            // Zero one entry a cycle.
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in        = req_chan.opcode;
               px_in        = req_chan.point_x;
               py_in        = req_chan.point_y;
               ci_in        = req_chan.cell_index;
               res_oor_in   = 1'b0;
               res_count_in = '0;
               res_empty_in = 1'b0;
               for (int i = 0; i < 4; i++) begin
                  bar_in[i] = '0;
               end
               case (req_chan.opcode)
                  OP_ADD:   state_in = S_BINX;
                  OP_READ:  state_in = S_RD_CHK;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_BINX: begin
            if (g_eff == '0 || area_width_ff == '0 || px_ff < area_left_ff) begin
               res_oor_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_BITS'(binx_prod);
               div_req.divisor  = area_width_ff;
               state_in         = S_BINX_WAIT;
            end
         end
         S_BINX_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= DIV_BITS'(g_eff)) begin
                  res_oor_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  col_in   = div_rsp.quotient[G_BITS-1:0];
                  state_in = S_BINY;
               end
            end
         end
         S_BINY: begin
            if (area_height_ff == '0 || py_ff < area_top_ff) begin
               res_oor_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_BITS'(biny_prod);
               div_req.divisor  = area_height_ff;
               state_in         = S_BINY_WAIT;
            end
         end
         S_BINY_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= DIV_BITS'(g_eff)) begin
                  res_oor_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  row_in   = div_rsp.quotient[G_BITS-1:0];
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            addr_in  = ADDR_BITS'((2 * G_BITS + 1)'(col_ff) +
                                  (2 * G_BITS + 1)'(row_ff) * (2 * G_BITS + 1)'(g_eff));
            state_in = S_INC_RD;
         end
         S_INC_RD: begin
            ram_re   = 1'b1;
            state_in = S_INC_WR;
         end
         S_INC_WR: begin
            if (ram_rdata != COUNT_MAX) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata + 1'b1;
            end
            state_in = S_DONE;
         end
         S_RD_CHK: begin
            if (g_eff == '0 || (2 * G_BITS)'(ci_ff) >= g_sq) begin
               res_oor_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               // Fetch the count now; the read data holds until the next read.
               ram_re           = 1'b1;
               ram_raddr        = ADDR_BITS'(ci_ff);
               div_req.start    = 1'b1;
               div_req.dividend = DIV_BITS'(ci_ff);
               div_req.divisor  = SPAN_BITS'(g_eff);
               state_in         = S_RD_WAIT;
            end
         end
         S_RD_WAIT: begin
            if (div_rsp.done) begin
               row_in       = div_rsp.quotient[G_BITS-1:0];
               col_in       = div_rsp.remainder[G_BITS-1:0];
               res_count_in = sat_count(ram_rdata);
               res_empty_in = (ram_rdata == '0);
               step_in      = '0;
               state_in     = S_EDGE;
            end
         end
         S_EDGE: begin
            div_req.start    = 1'b1;
            div_req.dividend = edge_dividend;
            div_req.divisor  = SPAN_BITS'(g_eff);
            state_in         = S_EDGE_WAIT;
         end
         S_EDGE_WAIT: begin
            if (div_rsp.done) begin
               bar_in[step_ff] = edge_val[EDGE_BITS-1:0];
               step_in         = step_ff + 1'b1;
               state_in        = (step_ff == 2'd3) ? S_DONE : S_EDGE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         sweep_ff       <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         area_left_ff   <= RST_AREA_LEFT;
         area_top_ff    <= RST_AREA_TOP;
         area_width_ff  <= RST_AREA_WIDTH;
         area_height_ff <= RST_AREA_HEIGHT;
         grid_size_ff   <= RST_GRID_SIZE;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         area_left_ff   <= area_left_in;
         area_top_ff    <= area_top_in;
         area_width_ff  <= area_width_in;
         area_height_ff <= area_height_in;
         grid_size_ff   <= grid_size_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      ci_ff        <= ci_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      addr_ff      <= addr_in;
      res_oor_ff   <= res_oor_in;
      res_count_ff <= res_count_in;
      res_empty_ff <= res_empty_in;
      bar_ff       <= bar_in;
      if (rsp_load) begin
         rsp_oor_ff   <= res_oor_ff;
         rsp_count_ff <= res_count_ff;
         rsp_empty_ff <= res_empty_ff;
         rsp_bar_ff   <= bar_ff;
      end
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;
   assign rsp_chan.cell_count   = rsp_count_ff;
   assign rsp_chan.cell_empty   = rsp_empty_ff;
   assign rsp_chan.bar_x_left   = rsp_bar_ff[0];
   assign rsp_chan.bar_x_right  = rsp_bar_ff[1];
   assign rsp_chan.bar_z_near   = rsp_bar_ff[2];
   assign rsp_chan.bar_z_far    = rsp_bar_ff[3];

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_count_ff == '0))
      else $error("empty cell reported with a nonzero count");

   a_oor_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (!rsp_empty_ff && rsp_count_ff == '0))
      else $error("out-of-range item carries cell data");

   a_ram_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_INIT || state_ff == S_CLEAR || state_ff == S_INC_WR))
      else $error("count memory written outside sweep or increment");

   a_no_op_unused: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BINX) |-> (op_ff == OP_ADD))
      else $error("binning started for an item that is not an add");

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gdh_pkg::*;

   // The package has no name for the fourth opcode, which the block must
   // take and answer with an all-zero result.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 100;
   // The longest operation is a clear, which sweeps all cells, so after the
   // last result we listen a little longer than one sweep for stray items.
   localparam int DRAIN_CYCLES    = CELLS + 76;
   // The slowest correct run is about 850 clears with the longest gaps on both
   // sides. The limit is several times that.
   localparam int TIMEOUT_NS      = 40_000_000;

   // One request item as it sits on the request channel.
   typedef struct packed {
      logic [OP_BITS-1:0]    opcode;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic [IDX_BITS-1:0]   cell_index;
   } hist_cmd_type;

   // One result item. The bar edges are kept as raw two's complement bits.
   typedef struct packed {
      logic                      out_of_range;
      logic [OUT_COUNT_BITS-1:0] cell_count;
      logic                      cell_empty;
      logic [EDGE_BITS-1:0]      bar_x_left;
      logic [EDGE_BITS-1:0]      bar_x_right;
      logic [EDGE_BITS-1:0]      bar_z_near;
      logic [EDGE_BITS-1:0]      bar_z_far;
   } hist_result_type;

   // Clock, reset and the configuration port. All of them hold a known value
   // from time zero; reset is asserted from the start and released once.
   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // The channels are driven from local registers through continuous
   // assignments, so each signal has a single driver and a known start value.
   logic         req_valid = 1'b0;
   hist_cmd_type req_word  = '0;
   logic         rsp_ready = 1'b0;

   gdh_req_if req_chan();
   gdh_rsp_if rsp_chan();

   assign req_chan.valid      = req_valid;
   assign req_chan.opcode     = req_word.opcode;
   assign req_chan.point_x    = req_word.point_x;
   assign req_chan.point_y    = req_word.point_y;
   assign req_chan.cell_index = req_word.cell_index;
   assign rsp_chan.ready      = rsp_ready;

   grid_density_histogram_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #4 clock = ~clock;

   // Our own copy of the configuration registers and of the cell counts.
   logic [SPAN_BITS-1:0]  shadow_left   = RST_AREA_LEFT;
   logic [SPAN_BITS-1:0]  shadow_top    = RST_AREA_TOP;
   logic [SPAN_BITS-1:0]  shadow_width  = RST_AREA_WIDTH;
   logic [SPAN_BITS-1:0]  shadow_height = RST_AREA_HEIGHT;
   logic [G_BITS-1:0]     shadow_grid   = RST_GRID_SIZE;
   logic [COUNT_BITS-1:0] cell_tally [CELLS];

   // Items waiting to be sent, and the results owed by the block, oldest first.
   hist_cmd_type    pending_cmds[$];
   hist_result_type expected_results[$];

   // Idle behavior: each side draws a wait of 0 to its maximum per item.
   // A maximum of zero gives a stretch with no idling on that side.
   int req_gap_max = 11;
   int rsp_gap_max = 11;

   // Driver state, private to the driver process.
   bit           cmd_presented = 1'b0;
   hist_cmd_type cmd_held      = '0;
   int           req_idle      = 0;
   int           rsp_idle      = 0;

   // Tallies for the closing summary and the verdict.
   int adds_seen       = 0;
   int reads_seen      = 0;
   int clears_seen     = 0;
   int unused_seen     = 0;
   int dropped_points  = 0;
   int occupied_reads  = 0;
   int results_checked = 0;
   int settings_used   = 0;
   int mismatches      = 0;

   // The grid size in use: the register clamped to the largest grid built.
   function automatic int unsigned grid_in_use();
      return (shadow_grid > G_BITS'(MAX_GRID)) ? MAX_GRID : int'(shadow_grid);
   endfunction

   // Bins one coordinate into a column or row. Anything before the area's
   // origin, past its far edge, or on a zero span or zero grid is rejected.
   function automatic bit bin_coord(input int unsigned p, input int unsigned origin,
                                    input int unsigned span, input int unsigned g,
                                    output int unsigned idx);
      int unsigned slot;
      idx = 0;
      if (g == 0 || span == 0 || p < origin) return 1'b0;
      slot = ((p - origin) * g) / span;
      if (slot >= g) return 1'b0;
      idx = slot;
      return 1'b1;
   endfunction

   // Cell boundary k of an axis in Q4 pixels, measured from the area's
   // center and rounded half up: 16*k*span/g - 8*span.
   function automatic logic [EDGE_BITS-1:0] bar_edge(input int unsigned k,
                                                     input int unsigned span,
                                                     input int unsigned g);
      int unsigned pos;
      int          centered;
      pos      = (16 * k * span + g / 2) / g;
      centered = int'(pos) - int'(8 * span);
      return EDGE_BITS'(centered);
   endfunction

   // Applies one accepted item to our copy of the counts and returns the
   // result the block owes for it.
   function automatic hist_result_type histogram_apply(input hist_cmd_type cmd);
      hist_result_type res;
      int unsigned     g, col, row, cell_no;
      bit              col_ok, row_ok;
      res = '0;
      g   = grid_in_use();
      case (cmd.opcode)
         OP_ADD: begin
            adds_seen++;
            col_ok = bin_coord(cmd.point_x, shadow_left, shadow_width, g, col);
            row_ok = bin_coord(cmd.point_y, shadow_top, shadow_height, g, row);
            if (col_ok && row_ok) begin
               cell_no = (col + row * g) % CELLS;
               // Counts saturate instead of wrapping.
               if (cell_tally[cell_no] != COUNT_MAX) cell_tally[cell_no]++;
            end else begin
               res.out_of_range = 1'b1;
               dropped_points++;
            end
         end
         OP_READ: begin
            reads_seen++;
            if (g == 0 || int'(cmd.cell_index) >= g * g) begin
               res.out_of_range = 1'b1;
            end else begin
               cell_no = cmd.cell_index;
               col     = cell_no % g;
               row     = cell_no / g;
               res.cell_count = (cell_tally[cell_no] > {OUT_COUNT_BITS{1'b1}}) ?
                                '1 : OUT_COUNT_BITS'(cell_tally[cell_no]);
               res.cell_empty = (cell_tally[cell_no] == '0);
               if (!res.cell_empty) occupied_reads++;
               // Edges are reported for empty cells as well.
               res.bar_x_left  = bar_edge(col, shadow_width, g);
               res.bar_x_right = bar_edge(col + 1, shadow_width, g);
               res.bar_z_near  = bar_edge(row, shadow_height, g);
               res.bar_z_far   = bar_edge(row + 1, shadow_height, g);
            end
         end
         OP_CLEAR: begin
            clears_seen++;
            foreach (cell_tally[i]) cell_tally[i] = '0;
         end
         default: begin
            unused_seen++;
         end
      endcase
      return res;
   endfunction

   // Picks a coordinate along one axis. Most land inside the area so that the
   // counts build up; some sit right on its borders and the rest anywhere.
   function automatic logic [COORD_BITS-1:0] pick_coord(input int unsigned origin,
                                                        input int unsigned span);
      int unsigned roll, hi;
      roll = $urandom_range(0, 99);
      if (span == 0 || roll >= 90) return COORD_BITS'($urandom_range(0, 1023));
      hi = origin + span - 1;
      if (hi > 1023) hi = 1023;
      if (roll < 78) return COORD_BITS'($urandom_range(origin, hi));
      case (roll % 3)
         0:       return COORD_BITS'(origin - 1);
         1:       return COORD_BITS'(origin + span);
         default: return COORD_BITS'(hi);
      endcase
   endfunction

   // One random item: mostly adds and reads, the odd clear and unused code.
   // Fields that the operation ignores still carry random values.
   function automatic hist_cmd_type random_command();
      hist_cmd_type cmd;
      int unsigned  pick, g;
      g              = grid_in_use();
      pick           = $urandom_range(0, 99);
      cmd.point_x    = COORD_BITS'($urandom_range(0, 1023));
      cmd.point_y    = COORD_BITS'($urandom_range(0, 1023));
      cmd.cell_index = IDX_BITS'($urandom_range(0, 1023));
      if (pick < 55) begin
         cmd.opcode  = OP_ADD;
         cmd.point_x = pick_coord(shadow_left, shadow_width);
         cmd.point_y = pick_coord(shadow_top, shadow_height);
      end else if (pick < 95) begin
         cmd.opcode = OP_READ;
         if (g != 0 && $urandom_range(0, 99) < 85) begin
            cmd.cell_index = IDX_BITS'($urandom_range(0, g * g - 1));
         end
      end else if (pick < 97) begin
         cmd.opcode = OP_CLEAR;
      end else begin
         cmd.opcode = OP_UNUSED;
      end
      return cmd;
   endfunction

   task automatic queue_cmd(input logic [OP_BITS-1:0] op, input int unsigned x,
                            input int unsigned y, input int unsigned idx);
      hist_cmd_type cmd;
      cmd.opcode     = op;
      cmd.point_x    = COORD_BITS'(x);
      cmd.point_y    = COORD_BITS'(y);
      cmd.cell_index = IDX_BITS'(idx);
      pending_cmds   = {pending_cmds, cmd};
   endtask

   // One register write: the enable is high for exactly one clock edge.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_AREA_LEFT:   shadow_left   = val[SPAN_BITS-1:0];
         CSR_AREA_TOP:    shadow_top    = val[SPAN_BITS-1:0];
         CSR_AREA_WIDTH:  shadow_width  = val[SPAN_BITS-1:0];
         CSR_AREA_HEIGHT: shadow_height = val[SPAN_BITS-1:0];
         CSR_GRID_SIZE:   shadow_grid   = val[G_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input int unsigned left, input int unsigned top,
                                input int unsigned width, input int unsigned height,
                                input int unsigned grid);
      write_reg(CSR_AREA_LEFT,   CSR_DATA_BITS'(left));
      write_reg(CSR_AREA_TOP,    CSR_DATA_BITS'(top));
      write_reg(CSR_AREA_WIDTH,  CSR_DATA_BITS'(width));
      write_reg(CSR_AREA_HEIGHT, CSR_DATA_BITS'(height));
      write_reg(CSR_GRID_SIZE,   CSR_DATA_BITS'(grid));
      settings_used++;
   endtask

   // Every item produces exactly one result, so the block is idle once all
   // queued items were taken and every owed result has come back.
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || cmd_presented || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Request driver. An item stays on the channel until the block takes it;
   // at that edge its result is predicted, and the next item goes out after
   // a freshly drawn wait. valid gets a single assignment per edge, so a
   // back-to-back item simply keeps it high.
   always @(posedge clock) begin
      if (reset) begin
         cmd_presented = 1'b0;
         req_idle      = $urandom_range(0, req_gap_max);
         req_valid    <= 1'b0;
      end else begin
         if (cmd_presented && req_chan.ready === 1'b1) begin
            expected_results = {expected_results, histogram_apply(cmd_held)};
            cmd_presented    = 1'b0;
            req_idle         = $urandom_range(0, req_gap_max);
         end
         if (!cmd_presented) begin
            if (req_idle > 0) begin
               req_idle--;
            end else if (pending_cmds.size() != 0) begin
               cmd_held      = pending_cmds.pop_front();
               cmd_presented = 1'b1;
            end
         end
         req_valid <= cmd_presented;
         req_word  <= cmd_held;
      end
   end

   // Result monitor. Each result taken is compared field by field with the
   // oldest prediction; after each one, ready drops for a drawn number of
   // cycles, so stalls land on every phase of the block's work.
   always @(posedge clock) begin
      hist_result_type got;
      hist_result_type want;
      if (reset) begin
         rsp_idle   = $urandom_range(0, rsp_gap_max);
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_ready) begin
            got.out_of_range = rsp_chan.out_of_range;
            got.cell_count   = rsp_chan.cell_count;
            got.cell_empty   = rsp_chan.cell_empty;
            got.bar_x_left   = rsp_chan.bar_x_left;
            got.bar_x_right  = rsp_chan.bar_x_right;
            got.bar_z_near   = rsp_chan.bar_z_near;
            got.bar_z_far    = rsp_chan.bar_z_far;
            if (expected_results.size() == 0) begin
               $display("%0t ns: result item with none expected, expected nothing, got %h",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               check_field("out_of_range", want.out_of_range, got.out_of_range);
               check_field("cell_count", want.cell_count, got.cell_count);
               check_field("cell_empty", want.cell_empty, got.cell_empty);
               check_field("bar_x_left", $signed(want.bar_x_left), $signed(got.bar_x_left));
               check_field("bar_x_right", $signed(want.bar_x_right), $signed(got.bar_x_right));
               check_field("bar_z_near", $signed(want.bar_z_near), $signed(got.bar_z_near));
               check_field("bar_z_far", $signed(want.bar_z_far), $signed(got.bar_z_far));
            end
            rsp_idle = $urandom_range(0, rsp_gap_max);
         end
         if (rsp_idle > 0) begin
            rsp_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and sequencing.
   initial begin
      foreach (cell_tally[i]) cell_tally[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The first directed items run at the reset settings: a 10 by 10 grid
      // over 640 by 480 pixels. They hit both far corners, the far edges,
      // an empty cell, indexes past the grid, the unused opcode and a clear.
      queue_cmd(OP_ADD, 0, 0, 1023);
      queue_cmd(OP_ADD, 639, 479, 0);
      queue_cmd(OP_ADD, 640, 0, 0);
      queue_cmd(OP_ADD, 0, 480, 0);
      queue_cmd(OP_ADD, 1023, 1023, 1023);
      queue_cmd(OP_READ, 1023, 1023, 0);
      queue_cmd(OP_READ, 0, 0, 99);
      queue_cmd(OP_READ, 0, 0, 1);
      queue_cmd(OP_READ, 0, 0, 100);
      queue_cmd(OP_READ, 0, 0, 1023);
      queue_cmd(OP_UNUSED, 1023, 1023, 1023);
      queue_cmd(OP_CLEAR, 1023, 1023, 1023);
      queue_cmd(OP_READ, 0, 0, 0);
      wait_idle();

      // A grid size above the largest grid is clamped to 32 cells per side.
      // Points just left of and just above the area are dropped, the far
      // corner lands, and the last cell shows the widest bar edges.
      apply_setting(100, 50, 1023, 1023, 63);
      queue_cmd(OP_ADD, 99, 60, 0);
      queue_cmd(OP_ADD, 200, 49, 0);
      queue_cmd(OP_ADD, 1023, 1023, 0);
      queue_cmd(OP_READ, 0, 0, 1023);
      queue_cmd(OP_READ, 0, 0, 0);
      wait_idle();

      // With a zero grid every add and every read is out of range.
      apply_setting(100, 50, 1023, 1023, 0);
      queue_cmd(OP_ADD, 500, 500, 0);
      queue_cmd(OP_READ, 0, 0, 0);
      wait_idle();

      // A zero width and height reject every add, but reads still work and
      // report zero edges. The count from the clamped grid above is kept
      // across the change of settings (cell 28 of row 30).
      apply_setting(0, 0, 0, 0, 32);
      queue_cmd(OP_ADD, 0, 0, 0);
      queue_cmd(OP_READ, 0, 0, 988);
      queue_cmd(OP_READ, 0, 0, 0);
      wait_idle();

      // Random phases, each under its own setting and idle style. Most adds
      // fall inside the area so that cells fill up and reads find counts.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_setting(0, 0, 640, 480, 10);
            1: apply_setting($urandom_range(0, 400), $urandom_range(0, 400),
                             $urandom_range(1, 1023), $urandom_range(1, 1023), 2);
            2: apply_setting(0, 0, 1023, 1023, 32);
            3: apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(1, 1023), $urandom_range(1, 1023),
                             $urandom_range(1, 32));
            4: apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(1, 1023), $urandom_range(1, 1023), 40);
            5: apply_setting(1023, 1023, 1, 1, 1);
            6: apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(1, 1023), $urandom_range(1, 1023), 0);
            default: apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   0, $urandom_range(1, 1023), 32);
         endcase
         case (p % 4)
            0: begin req_gap_max = 11; rsp_gap_max = 11; end
            1: begin req_gap_max = 0;  rsp_gap_max = 0;  end
            2: begin req_gap_max = 0;  rsp_gap_max = 11; end
            default: begin req_gap_max = 11; rsp_gap_max = 0; end
         endcase
         repeat (ITEMS_PER_PHASE) pending_cmds = {pending_cmds, random_command()};
         wait_idle();
      end

      // Any result that shows up now was never asked for.
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d adds (%0d dropped), %0d reads (%0d of filled cells), %0d clears, %0d unused.",
               adds_seen, dropped_points, reads_seen, occupied_reads, clears_seen, unused_seen);
      $display("Checked %0d results under %0d register settings.", results_checked, settings_used);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d items unsent and %0d results outstanding.",
               pending_cmds.size(), expected_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
